// File: src/rpd_pkg.sv
// Shared constants and types for the rotation packet deframer.
package rpd_pkg;

	// Number of stored payload bytes in one packet (1 to 9).
	localparam int PAYLOAD_BYTES = 9;

	// Number of matrix element fields in one result word.
	localparam int NUM_FIELDS = 9;

	// Width of the packet position counter.
	localparam int POS_W = 4;

	typedef logic [7:0] byte_t;
	typedef logic [POS_W-1:0] pos_t;

	// Packet positions: header, first payload byte, emit point and last byte.
	localparam pos_t POS_START      = pos_t'(0);
	localparam pos_t POS_TYPE       = pos_t'(1);
	localparam pos_t POS_FIRST_DATA = pos_t'(2);
	localparam pos_t POS_EMIT       = pos_t'(PAYLOAD_BYTES + 2);
	localparam pos_t POS_LAST       = pos_t'(PAYLOAD_BYTES + 4);

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_START_CHAR  = 1'b0,
		CFG_PACKET_TYPE = 1'b1
	} cfg_idx_t;

	// Register reset values.
	localparam byte_t START_CHAR_RST  = 8'd36;
	localparam byte_t PACKET_TYPE_RST = 8'd10;

endpackage

// File: src/rotation_packet_deframer_unit.sv
// Rotation packet deframer: frames 14-byte packets and emits the 3x3 matrix payload.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-------------------------------
//  input    | in_valid / in_stall   | rx_byte
//  output   | out_valid / out_stall | m0 .. m8
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each byte is registered on arrival and decoded in the following cycle; a
// result word passes through the input register and then the result
// register; one byte is taken every cycle unless the input is stalled.
// Only the byte at the emit position, the twelfth of a packet, waits when a
// previous result is still held by a stalled output; while it waits the input
// is stalled, and all other bytes pass while the output is stalled.
// Reset clears the framer to hunting at position 0 and loads the default
// start and type bytes; the payload bytes are not reset.
module rotation_packet_deframer_unit
	import rpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Byte input
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	// Matrix output
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [7:0] m0,
	output logic signed [7:0] m1,
	output logic signed [7:0] m2,
	output logic signed [7:0] m3,
	output logic signed [7:0] m4,
	output logic signed [7:0] m5,
	output logic signed [7:0] m6,
	output logic signed [7:0] m7,
	output logic signed [7:0] m8,
	// Configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	byte_t start_char_q;
	byte_t packet_type_q;
	logic  locked_q;
	pos_t  pos_q;
	byte_t payload_q [PAYLOAD_BYTES];

	logic  valid_s1;
	byte_t byte_s1;

	logic  out_valid_q;
	byte_t out_q [NUM_FIELDS];

	logic  locked_nxt;
	pos_t  pos_nxt;
	logic  emit;
	logic  store;
	logic  advance;
	logic  load_out;

	// Configuration registers accept a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q  <= START_CHAR_RST;
			packet_type_q <= PACKET_TYPE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_CHAR:  start_char_q  <= cfg_data;
				CFG_PACKET_TYPE: packet_type_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Framing decision for the registered byte.
	always_comb begin
		locked_nxt = locked_q;
		pos_nxt    = pos_q;
		emit       = 1'b0;
		store      = 1'b0;
		priority if (!locked_q) begin
			if (byte_s1 == start_char_q) begin
				locked_nxt = 1'b1;
				pos_nxt    = POS_TYPE;
			end
		end else if (pos_q == POS_START) begin
			if (byte_s1 == start_char_q) begin
				pos_nxt = POS_TYPE;
			end else begin
				locked_nxt = 1'b0;
			end
		end else if (pos_q == POS_TYPE) begin
			if (byte_s1 == packet_type_q) begin
				pos_nxt = POS_FIRST_DATA;
			end else begin
				locked_nxt = 1'b0;
			end
		end else if (pos_q < POS_EMIT) begin
			store   = 1'b1;
			pos_nxt = pos_q + pos_t'(1);
		end else if (pos_q == POS_EMIT) begin
			emit    = 1'b1;
			pos_nxt = pos_q + pos_t'(1);
		end else if (pos_q < POS_LAST) begin
			pos_nxt = pos_q + pos_t'(1);
		end else if (pos_q == POS_LAST) begin
			pos_nxt = POS_START;
		end else begin
			locked_nxt = 1'b0;
		end
	end

	// The decoded byte retires unless it must emit into a full, stalled output.
	assign in_stall = valid_s1 && emit && out_valid_q && out_stall;
	assign advance  = valid_s1 && !in_stall;
	assign load_out = advance && emit;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Framer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= 1'b0;
			pos_q    <= POS_START;
		end else if (advance) begin
			locked_q <= locked_nxt;
			pos_q    <= pos_nxt;
		end
	end

	// Payload bytes, one slot per data position.
	always_ff @(posedge clk) begin
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			if (advance && store && pos_q == POS_FIRST_DATA + pos_t'(k)) begin
				payload_q[k] <= byte_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_field
		if (g < PAYLOAD_BYTES) begin : g_used
			always_ff @(posedge clk) begin
				if (load_out) begin
					out_q[g] <= payload_q[g];
				end
			end
		end else begin : g_unused
			always_ff @(posedge clk) begin
				if (load_out) begin
					out_q[g] <= '0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign m0 = $signed(out_q[0]);
	assign m1 = $signed(out_q[1]);
	assign m2 = $signed(out_q[2]);
	assign m3 = $signed(out_q[3]);
	assign m4 = $signed(out_q[4]);
	assign m5 = $signed(out_q[5]);
	assign m6 = $signed(out_q[6]);
	assign m7 = $signed(out_q[7]);
	assign m8 = $signed(out_q[8]);

`ifndef SYNTHESIS
	// A loaded result always leaves the framer just past the emit position.
	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (pos_q == POS_EMIT + pos_t'(1) && locked_q && out_valid_q))
		else $error("result loaded without moving past the emit position");

	// Input only waits behind an emit byte that meets a stalled full output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && locked_q && pos_q == POS_EMIT && out_valid_q))
		else $error("input stalled without a blocked emit");

	// The position never leaves the packet range.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("packet position out of range");
`endif

endmodule
